// ----- hdl/slfr_pkg.sv -----
// Package for the segment LCD number framer.
// Frame constants, digit-to-segment tables and the request type shared by all modules.
// No dependencies.
package slfr_pkg;

  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned VALUE_W   = 14;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned FRAME_CNT_W = 3;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;
  localparam logic [FRAME_W-1:0] DATA_BASE = 16'hA000;
  localparam logic               CMD_BASE_BIT = 1'b1;
  localparam logic [FRAME_CNT_W-1:0] LAST_ADDR = 3'd7;

  localparam logic MODE_NUMBER  = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  typedef struct packed {
    logic                                mode;
    logic                                err;
    logic [CMD_W-1:0]                    cmd;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digit;
  } slfr_req_t;

  // High segment nibble of a decimal digit (even addresses)
  function automatic logic [3:0] seg_hi(input logic [DIGIT_W-1:0] d);
    logic [3:0] n;
    case (d)
      4'd0:    n = 4'hB;
      4'd1:    n = 4'h0;
      4'd2:    n = 4'h7;
      4'd3:    n = 4'h5;
      4'd4:    n = 4'hC;
      4'd5:    n = 4'hD;
      4'd6:    n = 4'hF;
      4'd7:    n = 4'h8;
      4'd8:    n = 4'hF;
      4'd9:    n = 4'hD;
      default: n = 4'h0;
    endcase
    return n;
  endfunction

  // Low segment nibble of a decimal digit (odd addresses)
  function automatic logic [3:0] seg_lo(input logic [DIGIT_W-1:0] d);
    logic [3:0] n;
    case (d)
      4'd0:    n = 4'hE;
      4'd1:    n = 4'h6;
      4'd2:    n = 4'hC;
      4'd3:    n = 4'hE;
      4'd4:    n = 4'h6;
      4'd5:    n = 4'hA;
      4'd6:    n = 4'hA;
      4'd7:    n = 4'hE;
      4'd8:    n = 4'hE;
      4'd9:    n = 4'hE;
      default: n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/segment_lcd_number_framer.sv -----
// Segment LCD number framer: a transaction passes the split stages and the sequencer's
// request and output registers. Throughput: one frame per cycle unless stalled; a number
// takes eight frames, a command or a range error one. The sequencer's frame counter sets
// that rate; the split stages take a new transaction every cycle while they have room.
// Synchronous active-high reset empties all stages; no transaction is in flight after it.
module segment_lcd_number_framer import slfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 mode,
  input  logic [VALUE_W-1:0]   value,
  input  logic [CMD_W-1:0]     command_byte,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [FRAME_W-1:0]   frame,
  output logic                 last,
  output logic                 error
);

  logic       mid_valid;
  logic       mid_ready;
  slfr_req_t  mid_req;

  slfr_digits u_digits (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req_valid),
    .in_stall     (req_stall),
    .mode         (mode),
    .value        (value),
    .command_byte (command_byte),
    .req_valid    (mid_valid),
    .req_ready    (mid_ready),
    .req          (mid_req)
  );

  slfr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req_valid (mid_valid),
    .req_ready (mid_ready),
    .req       (mid_req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .frame     (frame),
    .last      (last),
    .error     (error)
  );

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> last && (frame == '0))
    else $error("error transaction must be a single zero frame");

  a_data_hdr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last |-> frame[15:13] == 3'b101)
    else $error("non-final frame is not a data frame");

  a_data_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && frame[15:13] == 3'b101 && !error |-> last == (frame[9:7] == LAST_ADDR))
    else $error("last flag does not match data frame address");
`endif

endmodule

// ----- hdl/slfr_digits.sv -----
// Three-stage decimal split of the request value (thousands, hundreds, tens/ones).
// Depends on slfr_pkg.
// Each stage moves when empty or when the stage after it moves.
module slfr_digits import slfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [VALUE_W-1:0]   value,
  input  logic [CMD_W-1:0]     command_byte,
  output logic                 req_valid,
  input  logic                 req_ready,
  output slfr_req_t            req
);

  logic                s1_valid;
  logic                s1_mode;
  logic                s1_err;
  logic [CMD_W-1:0]    s1_cmd;
  logic [DIGIT_W-1:0]  s1_d0;
  logic [9:0]          s1_rem;

  logic                s2_valid;
  logic                s2_mode;
  logic                s2_err;
  logic [CMD_W-1:0]    s2_cmd;
  logic [DIGIT_W-1:0]  s2_d0;
  logic [DIGIT_W-1:0]  s2_d1;
  logic [6:0]          s2_rem;

  logic                s3_valid;
  slfr_req_t           s3_req;

  logic                adv1, adv2, adv3;

  logic [DIGIT_W-1:0]  d0_c, d1_c, d2_c, d3_c;
  logic [9:0]          rem0_c;
  logic [6:0]          rem1_c;
  logic [6:0]          rem2_c;

  assign adv3     = !s3_valid || req_ready;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  // thousands
  always_comb begin
    d0_c   = '0;
    rem0_c = value[9:0];
    for (int k = 1; k <= 9; k++) begin
      if (value >= VALUE_W'(k * 1000)) begin
        d0_c   = DIGIT_W'(k);
        rem0_c = 10'(value - VALUE_W'(k * 1000));
      end
    end
  end

  // hundreds
  always_comb begin
    d1_c   = '0;
    rem1_c = s1_rem[6:0];
    for (int k = 1; k <= 9; k++) begin
      if (s1_rem >= 10'(k * 100)) begin
        d1_c   = DIGIT_W'(k);
        rem1_c = 7'(s1_rem - 10'(k * 100));
      end
    end
  end

  // tens and ones
  always_comb begin
    d2_c   = '0;
    rem2_c = s2_rem;
    for (int k = 1; k <= 9; k++) begin
      if (s2_rem >= 7'(k * 10)) begin
        d2_c   = DIGIT_W'(k);
        rem2_c = 7'(s2_rem - 7'(k * 10));
      end
    end
    d3_c = rem2_c[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_mode <= mode;
      s1_err  <= (mode == MODE_NUMBER) && (value > VALUE_MAX);
      s1_cmd  <= command_byte;
      s1_d0   <= d0_c;
      s1_rem  <= rem0_c;
    end
    if (adv2 && s1_valid) begin
      s2_mode <= s1_mode;
      s2_err  <= s1_err;
      s2_cmd  <= s1_cmd;
      s2_d0   <= s1_d0;
      s2_d1   <= d1_c;
      s2_rem  <= rem1_c;
    end
    if (adv3 && s2_valid) begin
      s3_req.mode     <= s2_mode;
      s3_req.err      <= s2_err;
      s3_req.cmd      <= s2_cmd;
      s3_req.digit[0] <= s2_d0;
      s3_req.digit[1] <= s2_d1;
      s3_req.digit[2] <= d2_c;
      s3_req.digit[3] <= d3_c;
    end
  end

  assign req_valid = s3_valid;
  assign req       = s3_req;

endmodule

// ----- hdl/slfr_emit.sv -----
// Frame sequencer: holds one request and issues its frames through an output register.
// Depends on slfr_pkg.
module slfr_emit import slfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  slfr_req_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [FRAME_W-1:0]   frame,
  output logic                 last,
  output logic                 error
);

  logic                    busy;
  slfr_req_t               cur;
  logic [FRAME_CNT_W-1:0]  addr;
  logic                    out_load;
  logic                    cur_last;
  logic [FRAME_W-1:0]      frame_c;
  logic [DIGIT_W-1:0]      dig;
  logic [3:0]              nib;

  assign out_load  = !rsp_valid || !rsp_stall;
  assign cur_last  = (cur.mode == MODE_COMMAND) || cur.err || (addr == LAST_ADDR);
  assign req_ready = !busy || (out_load && cur_last);

  always_comb begin
    dig = cur.digit[addr[FRAME_CNT_W-1:1]];
    nib = addr[0] ? seg_lo(dig) : seg_hi(dig);
    if (cur.mode == MODE_COMMAND) begin
      frame_c = {CMD_BASE_BIT, 2'b00, cur.cmd, 5'b00000};
    end else if (cur.err) begin
      frame_c = '0;
    end else begin
      frame_c = DATA_BASE | {6'd0, addr, nib, 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      addr      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (out_load) rsp_valid <= busy;
      if (req_ready) begin
        busy <= req_valid;
        addr <= '0;
      end else if (busy && out_load) begin
        addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && busy) begin
      frame <= frame_c;
      last  <= cur_last;
      error <= (cur.mode == MODE_NUMBER) && cur.err;
    end
    if (req_ready && req_valid) cur <= req;
  end

endmodule
